@@ design/trilinear_voxel_upsample_threshold_top_defines.svh @@
// assertion helpers for the checker in tvu_checker.sv
// clocked on clk, idle while rst_n is low
`ifndef TRILINEAR_VOXEL_UPSAMPLE_THRESHOLD_TOP_DEFINES_SVH
`define TRILINEAR_VOXEL_UPSAMPLE_THRESHOLD_TOP_DEFINES_SVH

// same-cycle implication
`define TVU_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define TVU_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ design/tvu_pkg.sv @@
package tvu_pkg;

  // request kind carried on in_tuser
  typedef enum logic {
    ACT_LOAD  = 1'b0,
    ACT_QUERY = 1'b1
  } action_t;

  // field widths
  localparam int IDX_W    = 9;
  localparam int SAMPLE_W = 32;
  localparam int BXZ_W    = 4;
  localparam int BY_W     = 7;
  localparam int CODE_W   = 8;
  localparam int OFFSET_W = 15;

  // packed stream widths
  localparam int IN_TDATA_W  = 56;
  localparam int OUT_TDATA_W = 24;

  // cell spans: blocks per cell across and up
  localparam logic [3:0] SPAN_XZ = 4'd8;
  localparam logic [2:0] SPAN_Y  = 3'd4;

  // eight corners, one bank per corner parity
  localparam int NUM_BANKS = 8;
  localparam int WEIGHT_W  = 9;
  localparam int ACC_W     = 41;

  localparam logic [CODE_W-1:0] RESET_SOLID = 8'd121;

endpackage

@@ design/trilinear_voxel_upsample_threshold_top.sv @@
// Trilinear density upsampler with a positive-density threshold.
// in_* stream: in_tuser selects a sample load or a block query. A load writes one
// Q23.8 sample into the coarse grid and gives no result; a query gives exactly one
// result on the out_* stream: the solid code if the blended density is above zero,
// else 0, plus the packed block offset x<<11 | z<<7 | height.
// cfg_wr_en / cfg_wr_data set the solid code; write it only while the block is idle.
// Pipeline: an accepted query passes through stages one to seven and the output
// register before it shows on out_tvalid. Throughput: one request per cycle while
// out_tready holds, loads and queries mixed freely; a load is visible to any later
// query. The grid lives in eight banks, one per corner parity, so the eight corners
// of a cell are read in the same cycle, one read port per bank.
// Reset empties the pipeline and sets the solid code to 121; grid contents are
// not cleared, every sample must be loaded before a query touches it.
// When the receiver stalls, results hold on out_tdata and the stages behind fill
// up; in_tready drops only once every stage holds an item.
module trilinear_voxel_upsample_threshold_top
  import tvu_pkg::*;
#(
  parameter int CELLS_ACROSS = 2,
  parameter int CELLS_UP     = 32
) (
  input  logic                   clk,
  input  logic                   rst_n,
  // configuration
  input  logic                   cfg_wr_en,
  input  logic [CODE_W-1:0]      cfg_wr_data,
  // requests
  input  logic                   in_tvalid,
  output logic                   in_tready,
  // sample_index[8:0], sample_value[40:9], block_x[44:41], block_z[48:45], block_y[55:49]
  input  logic [IN_TDATA_W-1:0]  in_tdata,
  // action[0]
  input  logic                   in_tuser,
  // results
  output logic                   out_tvalid,
  input  logic                   out_tready,
  // block_code[7:0], block_offset[22:8], zero pad[23]
  output logic [OUT_TDATA_W-1:0] out_tdata
);

  localparam int DIM_XZ      = CELLS_ACROSS + 1;
  localparam int DIM_Y       = CELLS_UP + 1;
  localparam int GRID_DEPTH  = DIM_XZ * DIM_XZ * DIM_Y;
  localparam int HALF_XZ     = (DIM_XZ + 1) / 2;
  localparam int HALF_Y      = (DIM_Y + 1) / 2;
  localparam int BANK_DEPTH  = HALF_XZ * HALF_XZ * HALF_Y;
  localparam int AW          = (BANK_DEPTH > 1) ? $clog2(BANK_DEPTH) : 1;
  localparam int GXW         = $clog2(DIM_XZ);
  localparam int GYW         = $clog2(DIM_Y);
  localparam int NSTG        = 7;
  // reciprocal constants for the slot decomposition
  localparam int MW          = IDX_W + 1;
  localparam int PW          = 2 * IDX_W + 1;
  localparam int SH_Y        = IDX_W + $clog2(DIM_Y);
  localparam int SH_XZ       = IDX_W + $clog2(DIM_XZ);
  localparam int MUL_Y       = ((1 << SH_Y) + DIM_Y - 1) / DIM_Y;
  localparam int MUL_XZ      = ((1 << SH_XZ) + DIM_XZ - 1) / DIM_XZ;
  localparam logic [MW-1:0] RCP_Y  = MW'(MUL_Y);
  localparam logic [MW-1:0] RCP_XZ = MW'(MUL_XZ);

  function automatic logic [AW-1:0] bank_addr(input int xh, input int zh, input int yh);
    bank_addr = AW'((xh * HALF_XZ + zh) * HALF_Y + yh);
  endfunction

  // handshake and stage valids
  logic [NSTG:1]   stg_vld_r;
  logic [NSTG:1]   vld_nxt;
  logic [NSTG+1:1] rdy;
  logic            out_vld_r;
  logic [CODE_W-1:0] solid_code_r;

  // request fields
  action_t                in_act;
  logic [IDX_W-1:0]       in_idx;
  logic signed [SAMPLE_W-1:0] in_val;
  logic [BXZ_W-1:0]       in_bx;
  logic [BXZ_W-1:0]       in_bz;
  logic [BY_W-1:0]        in_by;

  // stage 1
  action_t                s1_act_r;
  logic [IDX_W-1:0]       s1_idx_r;
  logic signed [SAMPLE_W-1:0] s1_val_r;
  logic [BXZ_W-1:0]       s1_bx_r;
  logic [BXZ_W-1:0]       s1_bz_r;
  logic [BY_W-1:0]        s1_by_r;
  logic [PW-1:0]          s1_qy_prod;
  logic [PW-1:0]          s1_qy_shift;
  logic                   s1_inside;

  // stage 2
  action_t                s2_act_r;
  logic [IDX_W-1:0]       s2_idx_r;
  logic signed [SAMPLE_W-1:0] s2_val_r;
  logic [IDX_W-1:0]       s2_qy_r;
  logic                   s2_cx_r;
  logic                   s2_cz_r;
  logic [4:0]             s2_cy_r;
  logic [2:0]             s2_fx_r;
  logic [2:0]             s2_fz_r;
  logic [1:0]             s2_fy_r;
  logic                   s2_inside_r;
  logic [OFFSET_W-1:0]    s2_off_r;
  logic [IDX_W-1:0]       s2_gy_full;
  logic [PW-1:0]          s2_gx_prod;
  logic [PW-1:0]          s2_gx_shift;
  logic [AW-1:0]          q_raddr [NUM_BANKS];
  logic [WEIGHT_W-1:0]    q_w     [NUM_BANKS];

  // stage 3
  action_t                s3_act_r;
  logic signed [SAMPLE_W-1:0] s3_val_r;
  logic [IDX_W-1:0]       s3_qy_r;
  logic [GXW-1:0]         s3_gx_r;
  logic [GYW-1:0]         s3_gy_r;
  logic                   s3_range_r;
  logic [AW-1:0]          s3_raddr_r [NUM_BANKS];
  logic [WEIGHT_W-1:0]    s3_w_r     [NUM_BANKS];
  logic                   s3_inside_r;
  logic [OFFSET_W-1:0]    s3_off_r;
  logic [IDX_W-1:0]       ld_gz_full;
  logic [GXW-1:0]         ld_gz;
  logic [2:0]             wr_bank;
  logic [AW-1:0]          wr_addr;
  logic                   wr_en;

  // stages 4 to 7
  logic signed [SAMPLE_W-1:0] s4_rd_r [NUM_BANKS];
  logic [WEIGHT_W-1:0]    s4_w_r  [NUM_BANKS];
  logic                   s4_inside_r;
  logic [OFFSET_W-1:0]    s4_off_r;
  logic signed [ACC_W-1:0] s5_prod_r [NUM_BANKS];
  logic                   s5_inside_r;
  logic [OFFSET_W-1:0]    s5_off_r;
  logic signed [ACC_W-1:0] s6_sum_r [NUM_BANKS/2];
  logic                   s6_inside_r;
  logic [OFFSET_W-1:0]    s6_off_r;
  logic signed [ACC_W-1:0] s7_sum_r [NUM_BANKS/4];
  logic                   s7_inside_r;
  logic [OFFSET_W-1:0]    s7_off_r;

  // output register
  logic signed [ACC_W-1:0] fin_sum;
  logic [CODE_W-1:0]      out_code_nxt;
  logic [CODE_W-1:0]      out_code_r;
  logic [OFFSET_W-1:0]    out_off_r;

  // unpack the request
  assign in_act = action_t'(in_tuser);
  assign in_idx = in_tdata[8:0];
  assign in_val = in_tdata[40:9];
  assign in_bx  = in_tdata[44:41];
  assign in_bz  = in_tdata[48:45];
  assign in_by  = in_tdata[55:49];

  // ready ripples back from the output register
  always_comb begin
    rdy[NSTG+1] = !out_vld_r || out_tready;
    for (int k = NSTG; k >= 1; k--) begin
      rdy[k] = !stg_vld_r[k] || rdy[k+1];
    end
  end

  // valid entering each stage; loads leave after the grid write
  always_comb begin
    vld_nxt[1] = in_tvalid;
    for (int k = 2; k <= NSTG; k++) begin
      vld_nxt[k] = stg_vld_r[k-1];
    end
    vld_nxt[4] = stg_vld_r[3] && (s3_act_r == ACT_QUERY);
  end

  assign in_tready = rdy[1];

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stg_vld_r    <= '0;
      out_vld_r    <= 1'b0;
      solid_code_r <= RESET_SOLID;
    end else begin
      if (cfg_wr_en) begin
        solid_code_r <= cfg_wr_data;
      end
      for (int k = 1; k <= NSTG; k++) begin
        if (rdy[k]) begin
          stg_vld_r[k] <= vld_nxt[k];
        end
      end
      if (rdy[NSTG+1]) begin
        out_vld_r <= stg_vld_r[NSTG];
      end
    end
  end

  // stage 1: capture the request
  always_ff @(posedge clk) begin
    if (rdy[1]) begin
      s1_act_r <= in_act;
      s1_idx_r <= in_idx;
      s1_val_r <= in_val;
      s1_bx_r  <= in_bx;
      s1_bz_r  <= in_bz;
      s1_by_r  <= in_by;
    end
  end

  // slot / row count by reciprocal multiply
  assign s1_qy_prod  = {{MW{1'b0}}, s1_idx_r} * {{IDX_W{1'b0}}, RCP_Y};
  assign s1_qy_shift = s1_qy_prod >> SH_Y;

  // query lies in a cell of the grid
  assign s1_inside = ((CELLS_ACROSS > 1) || !s1_bx_r[3]) &&
                     ((CELLS_ACROSS > 1) || !s1_bz_r[3]) &&
                     ({2'b00, s1_by_r[6:2]} < 7'(CELLS_UP));

  // stage 2: cell, fractions and row count
  always_ff @(posedge clk) begin
    if (rdy[2]) begin
      s2_act_r    <= s1_act_r;
      s2_idx_r    <= s1_idx_r;
      s2_val_r    <= s1_val_r;
      s2_qy_r     <= s1_qy_shift[IDX_W-1:0];
      s2_cx_r     <= s1_bx_r[3];
      s2_cz_r     <= s1_bz_r[3];
      s2_cy_r     <= s1_by_r[6:2];
      s2_fx_r     <= s1_bx_r[2:0];
      s2_fz_r     <= s1_bz_r[2:0];
      s2_fy_r     <= s1_by_r[1:0];
      s2_inside_r <= s1_inside;
      s2_off_r    <= {s1_bx_r, s1_bz_r, s1_by_r};
    end
  end

  // load: height coordinate and x coordinate
  assign s2_gy_full  = s2_idx_r - IDX_W'(s2_qy_r * DIM_Y);
  assign s2_gx_prod  = {{MW{1'b0}}, s2_qy_r} * {{IDX_W{1'b0}}, RCP_XZ};
  assign s2_gx_shift = s2_gx_prod >> SH_XZ;

  // query: per-bank corner address and blend weight
  always_comb begin : q_corners
    logic [2:0] bsel;
    logic       dx;
    logic       dz;
    logic       dy;
    logic [1:0] gx;
    logic [1:0] gz;
    logic [5:0] gy;
    logic [3:0] wx;
    logic [3:0] wz;
    logic [2:0] wy;
    for (int b = 0; b < NUM_BANKS; b++) begin
      bsel = 3'(b);
      dx = bsel[2] ^ s2_cx_r;
      dz = bsel[1] ^ s2_cz_r;
      dy = bsel[0] ^ s2_cy_r[0];
      gx = {1'b0, s2_cx_r} + {1'b0, dx};
      gz = {1'b0, s2_cz_r} + {1'b0, dz};
      gy = {1'b0, s2_cy_r} + {5'b0, dy};
      wx = dx ? {1'b0, s2_fx_r} : SPAN_XZ - {1'b0, s2_fx_r};
      wz = dz ? {1'b0, s2_fz_r} : SPAN_XZ - {1'b0, s2_fz_r};
      wy = dy ? {1'b0, s2_fy_r} : SPAN_Y - {1'b0, s2_fy_r};
      q_raddr[b] = bank_addr(int'(gx[1]), int'(gz[1]), int'(gy[5:1]));
      q_w[b]     = {5'b0, wx} * {5'b0, wz} * {6'b0, wy};
    end
  end

  // stage 3: read addresses, load coordinates
  always_ff @(posedge clk) begin
    if (rdy[3]) begin
      s3_act_r    <= s2_act_r;
      s3_val_r    <= s2_val_r;
      s3_qy_r     <= s2_qy_r;
      s3_gx_r     <= s2_gx_shift[GXW-1:0];
      s3_gy_r     <= s2_gy_full[GYW-1:0];
      s3_range_r  <= (32'(s2_idx_r) < 32'(GRID_DEPTH));
      s3_raddr_r  <= q_raddr;
      s3_w_r      <= q_w;
      s3_inside_r <= s2_inside_r;
      s3_off_r    <= s2_off_r;
    end
  end

  // load: z coordinate, bank and bank address
  assign ld_gz_full = s3_qy_r - IDX_W'(s3_gx_r * DIM_XZ);
  assign ld_gz      = ld_gz_full[GXW-1:0];
  assign wr_bank    = {s3_gx_r[0], ld_gz[0], s3_gy_r[0]};
  assign wr_addr    = bank_addr(int'(s3_gx_r >> 1), int'(ld_gz >> 1), int'(s3_gy_r >> 1));
  assign wr_en      = stg_vld_r[3] && (s3_act_r == ACT_LOAD) && s3_range_r && rdy[4];

  // grid banks: one write port, one registered read port each
  for (genvar gb = 0; gb < NUM_BANKS; gb++) begin : g_bank
    logic signed [SAMPLE_W-1:0] bank_mem [BANK_DEPTH];

    always_ff @(posedge clk) begin
      if (wr_en && (wr_bank == 3'(gb))) begin
        bank_mem[wr_addr] <= s3_val_r;
      end
      if (rdy[4]) begin
        s4_rd_r[gb] <= bank_mem[s3_raddr_r[gb]];
      end
    end
  end

  // stage 4: corner samples arrive
  always_ff @(posedge clk) begin
    if (rdy[4]) begin
      s4_w_r      <= s3_w_r;
      s4_inside_r <= s3_inside_r;
      s4_off_r    <= s3_off_r;
    end
  end

  // stage 5: weighted corners
  always_ff @(posedge clk) begin
    if (rdy[5]) begin
      for (int b = 0; b < NUM_BANKS; b++) begin
        s5_prod_r[b] <= s4_rd_r[b] * $signed({1'b0, s4_w_r[b]});
      end
      s5_inside_r <= s4_inside_r;
      s5_off_r    <= s4_off_r;
    end
  end

  // stage 6: first adder level
  always_ff @(posedge clk) begin
    if (rdy[6]) begin
      for (int i = 0; i < NUM_BANKS / 2; i++) begin
        s6_sum_r[i] <= s5_prod_r[2*i] + s5_prod_r[2*i+1];
      end
      s6_inside_r <= s5_inside_r;
      s6_off_r    <= s5_off_r;
    end
  end

  // stage 7: second adder level
  always_ff @(posedge clk) begin
    if (rdy[7]) begin
      for (int i = 0; i < NUM_BANKS / 4; i++) begin
        s7_sum_r[i] <= s6_sum_r[2*i] + s6_sum_r[2*i+1];
      end
      s7_inside_r <= s6_inside_r;
      s7_off_r    <= s6_off_r;
    end
  end

  // final add and threshold
  assign fin_sum      = s7_sum_r[0] + s7_sum_r[1];
  assign out_code_nxt = (s7_inside_r && !fin_sum[ACC_W-1] && (fin_sum != '0)) ?
                        solid_code_r : '0;

  // output register
  always_ff @(posedge clk) begin
    if (rdy[NSTG+1]) begin
      out_code_r <= out_code_nxt;
      out_off_r  <= s7_off_r;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = {1'b0, out_off_r, out_code_r};

endmodule

@@ design/tvu_checker.sv @@
`include "trilinear_voxel_upsample_threshold_top_defines.svh"

module tvu_checker
  import tvu_pkg::*;
(
  input logic                   clk,
  input logic                   rst_n,
  input logic                   cfg_wr_en,
  input logic [CODE_W-1:0]      cfg_wr_data,
  input logic                   in_tvalid,
  input logic                   in_tready,
  input logic                   in_tuser,
  input logic                   out_tvalid,
  input logic                   out_tready,
  input logic [OUT_TDATA_W-1:0] out_tdata
);

  logic [CODE_W-1:0] code_shadow_r;
  logic [3:0]        pend_r;
  logic              q_in;
  logic              r_out;

  assign q_in  = in_tvalid && in_tready && (action_t'(in_tuser) == ACT_QUERY);
  assign r_out = out_tvalid && out_tready;

  // shadow of the solid code and count of queries still owed a result
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      code_shadow_r <= RESET_SOLID;
      pend_r        <= '0;
    end else begin
      if (cfg_wr_en) begin
        code_shadow_r <= cfg_wr_data;
      end
      pend_r <= pend_r + {3'b0, q_in} - {3'b0, r_out};
    end
  end

  // a result's code is either empty or the configured solid code
  `TVU_ASSERT_IMP(a_code_legal, out_tvalid, out_tdata[7:0] == 8'd0 || out_tdata[7:0] == code_shadow_r, "result code is neither zero nor the solid code")

  // every result belongs to an accepted query
  `TVU_ASSERT_IMP(a_no_orphan, out_tvalid, pend_r != 4'd0, "result without an outstanding query")

  // with the output empty the whole pipeline can move
  `TVU_ASSERT_IMP(a_ready_drained, !out_tvalid, in_tready, "input stalled while output is empty")

  // a stalled result holds
  `TVU_ASSERT_NXT(a_out_hold, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata), "stalled result changed")

endmodule

bind trilinear_voxel_upsample_threshold_top tvu_checker u_tvu_checker (.*);

@@ dv/tvu_block_checker.sv @@
module tvu_block_checker
  import tvu_pkg::*;
#(
  parameter int CELLS_ACROSS = 2,
  parameter int CELLS_UP     = 32
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   cfg_wr_en,
  input  logic [CODE_W-1:0]      cfg_wr_data,
  input  logic                   in_tvalid,
  input  logic                   in_tready,
  // sample_index, sample_value, block_x, block_z, block_y
  input  logic [IN_TDATA_W-1:0]  in_tdata,
  // action
  input  logic                   in_tuser,
  input  logic                   out_tvalid,
  input  logic                   out_tready,
  // block_code, block_offset, zero pad
  input  logic [OUT_TDATA_W-1:0] out_tdata,
  output int                     mismatches,
  output int                     results_due
);

  localparam int DIM_XZ     = CELLS_ACROSS + 1;
  localparam int DIM_Y      = CELLS_UP + 1;
  localparam int GRID_SLOTS = DIM_XZ * DIM_XZ * DIM_Y;
  localparam int BX_LSB     = IDX_W + SAMPLE_W;
  localparam int BZ_LSB     = BX_LSB + BXZ_W;
  localparam int BY_LSB     = BZ_LSB + BXZ_W;

  typedef struct packed {
    logic [CODE_W-1:0]   code;
    logic [OFFSET_W-1:0] offset;
  } block_result_t;

  // shadow copy of the coarse grid and the solid code
  logic signed [SAMPLE_W-1:0] density [GRID_SLOTS];
  logic [CODE_W-1:0]          solid_code = RESET_SOLID;
  block_result_t              blocks_due[$];
  int                         mismatch_count = 0;

  assign mismatches = mismatch_count;

  task automatic report_mismatch(input string what);
    mismatch_count++;
    if (mismatch_count <= 100) begin
      $display("[%0t] mismatch: %s", $time, what);
    end
  endtask

  // exact trilinear blend scaled by 256, then the positive-density threshold
  function automatic logic [CODE_W-1:0] threshold_block(input logic [BXZ_W-1:0] bx,
                                                        input logic [BXZ_W-1:0] bz,
                                                        input logic [BY_W-1:0]  by);
    int     cx, cz, cy, fx, fz, fy, wx, wz, wy, dx, dz, dy;
    longint acc;
    acc = 0;
    cx  = int'(bx) / int'(SPAN_XZ);
    fx  = int'(bx) % int'(SPAN_XZ);
    cz  = int'(bz) / int'(SPAN_XZ);
    fz  = int'(bz) % int'(SPAN_XZ);
    cy  = int'(by) / int'(SPAN_Y);
    fy  = int'(by) % int'(SPAN_Y);
    // block outside the grid is never solid
    if (cx >= CELLS_ACROSS || cz >= CELLS_ACROSS || cy >= CELLS_UP) begin
      return '0;
    end
    for (dx = 0; dx < 2; dx++) begin
      wx = dx ? fx : int'(SPAN_XZ) - fx;
      for (dz = 0; dz < 2; dz++) begin
        wz = dz ? fz : int'(SPAN_XZ) - fz;
        for (dy = 0; dy < 2; dy++) begin
          wy = dy ? fy : int'(SPAN_Y) - fy;
          acc += longint'(density[((cx + dx) * DIM_XZ + cz + dz) * DIM_Y + cy + dy])
                 * (wx * wz * wy);
        end
      end
    end
    return (acc > 0) ? solid_code : '0;
  endfunction

  always @(posedge clk) begin
    block_result_t    due;
    logic [IDX_W-1:0] idx;
    logic [BXZ_W-1:0] bx;
    logic [BXZ_W-1:0] bz;
    logic [BY_W-1:0]  by;
    if (!rst_n) begin
      solid_code = RESET_SOLID;
      blocks_due.delete();
    end else begin
      if (cfg_wr_en) begin
        solid_code = cfg_wr_data;
      end
      // result side first, so a stray result never meets a fresh expectation
      if (out_tvalid && out_tready) begin
        if (blocks_due.size() == 0) begin
          report_mismatch($sformatf("result %h with none outstanding", out_tdata));
        end else begin
          due = blocks_due.pop_front();
          if (out_tdata[CODE_W-1:0] !== due.code) begin
            report_mismatch($sformatf("block_code %h, predicted %h (offset %h)",
                                      out_tdata[CODE_W-1:0], due.code, due.offset));
          end
          if (out_tdata[CODE_W +: OFFSET_W] !== due.offset) begin
            report_mismatch($sformatf("block_offset %h, predicted %h",
                                      out_tdata[CODE_W +: OFFSET_W], due.offset));
          end
          if (out_tdata[OUT_TDATA_W-1:CODE_W+OFFSET_W] !== '0) begin
            report_mismatch($sformatf("pad bits set in result %h", out_tdata));
          end
        end
      end
      // request side: loads update the grid, queries queue a prediction
      if (in_tvalid && in_tready) begin
        idx = in_tdata[IDX_W-1:0];
        bx  = in_tdata[BX_LSB +: BXZ_W];
        bz  = in_tdata[BZ_LSB +: BXZ_W];
        by  = in_tdata[BY_LSB +: BY_W];
        if (action_t'(in_tuser) == ACT_LOAD) begin
          if (int'(idx) < GRID_SLOTS) begin
            density[idx] = in_tdata[IDX_W +: SAMPLE_W];
          end
        end else begin
          due.code   = threshold_block(bx, bz, by);
          due.offset = {bx, bz, by};
          blocks_due.push_back(due);
        end
      end
    end
    results_due <= blocks_due.size();
  end

endmodule

@@ dv/trilinear_voxel_upsample_threshold_top_tb.sv @@
module trilinear_voxel_upsample_threshold_top_tb;
  import tvu_pkg::*;

  localparam int GRID_SLOTS = 297;
  localparam int PHASES     = 5;
  localparam int PHASE_REQS = 216;

  logic                   clk;
  logic                   rst_n;
  logic                   cfg_wr_en;
  logic [CODE_W-1:0]      cfg_wr_data;
  logic                   in_tvalid;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata;
  logic                   in_tuser;
  logic                   out_tvalid;
  logic                   out_tready;
  logic [OUT_TDATA_W-1:0] out_tdata;
  int                     mismatches;
  int                     results_due;

  // idling odds in percent, zero in the calm tail
  int                     gap_pct   = 10;
  int                     stall_pct = 10;

  trilinear_voxel_upsample_threshold_top u_top (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata)
  );

  tvu_block_checker u_check (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .mismatches  (mismatches),
    .results_due (results_due)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // hard stop
  initial begin
    #1000000;
    $display("trilinear_voxel_upsample_threshold_top_tb NOT OK");
    $finish;
  end

  // receiver stalls in bursts
  initial begin
    out_tready <= 1'b0;
    forever begin
      @(posedge clk);
      if ($urandom_range(0, 99) < stall_pct) begin
        out_tready <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk);
        out_tready <= 1'b1;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  // hold one request until it is taken
  task automatic push_request(input action_t act, input logic [IN_TDATA_W-1:0] data);
    in_tvalid <= 1'b1;
    in_tuser  <= act;
    in_tdata  <= data;
    do @(posedge clk); while (!in_tready);
    if ($urandom_range(0, 99) < gap_pct) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
  endtask

  task automatic load_sample(input logic [IDX_W-1:0] idx, input logic [SAMPLE_W-1:0] value);
    logic [BXZ_W-1:0] bx;
    logic [BXZ_W-1:0] bz;
    logic [BY_W-1:0]  by;
    // query fields are ignored on a load, fill them with noise
    bx = BXZ_W'($urandom_range(0, 15));
    bz = BXZ_W'($urandom_range(0, 15));
    by = BY_W'($urandom_range(0, 127));
    push_request(ACT_LOAD, {by, bz, bx, value, idx});
  endtask

  task automatic query_block(input logic [BXZ_W-1:0] bx, input logic [BXZ_W-1:0] bz,
                             input logic [BY_W-1:0] by);
    logic [IDX_W-1:0]    idx;
    logic [SAMPLE_W-1:0] value;
    idx   = IDX_W'($urandom_range(0, 511));
    value = $urandom;
    push_request(ACT_QUERY, {by, bz, bx, value, idx});
  endtask

  // density values: extremes, near zero, or anything
  function automatic logic [SAMPLE_W-1:0] pick_sample();
    case ($urandom_range(0, 9))
      0:       return 32'h7FFF_FFFF;
      1:       return 32'h8000_0000;
      2:       return '0;
      3, 4:    return 32'(int'($urandom_range(0, 8)) - 4);
      default: return $urandom;
    endcase
  endfunction

  // stop sending until every result is back
  task automatic wait_drained();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (results_due != 0);
  endtask

  task automatic write_solid_code(input logic [CODE_W-1:0] code);
    wait_drained();
    // loads may still be in the pipeline after the last result
    repeat (12) @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= code;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
  endtask

  task automatic random_request();
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 60) begin
      query_block(BXZ_W'($urandom_range(0, 15)), BXZ_W'($urandom_range(0, 15)),
                  BY_W'($urandom_range(0, 127)));
    end else if (pick < 93) begin
      load_sample(IDX_W'($urandom_range(0, GRID_SLOTS - 1)), pick_sample());
    end else begin
      // slot past the grid, must be dropped
      load_sample(IDX_W'($urandom_range(GRID_SLOTS, 511)), pick_sample());
    end
  endtask

  initial begin
    int               s;
    int               p;
    int               k;
    logic [CODE_W-1:0] phase_code [PHASES];
    phase_code[0] = 8'hFF;
    phase_code[1] = 8'h00;
    phase_code[2] = CODE_W'($urandom_range(1, 254));
    phase_code[3] = 8'hA5;
    phase_code[4] = RESET_SOLID;

    rst_n       <= 1'b0;
    cfg_wr_en   <= 1'b0;
    cfg_wr_data <= '0;
    in_tvalid   <= 1'b0;
    in_tuser    <= ACT_LOAD;
    in_tdata    <= '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // fill the whole grid before any query
    for (s = 0; s < GRID_SLOTS; s++) begin
      load_sample(IDX_W'(s), pick_sample());
    end

    // corner weight only on slot 0 at the cell origin
    query_block(0, 0, 0);
    // exactly zero density is not solid
    load_sample(0, 32'd0);
    query_block(0, 0, 0);
    load_sample(0, 32'd1);
    query_block(0, 0, 0);
    load_sample(0, 32'hFFFF_FFFF);
    query_block(0, 0, 0);
    load_sample(0, 32'h7FFF_FFFF);
    query_block(0, 0, 0);
    load_sample(0, 32'h8000_0000);
    query_block(0, 0, 0);
    // far corner of the grid at the top block
    load_sample(IDX_W'(GRID_SLOTS - 1), 32'h7FFF_FFFF);
    query_block(15, 15, 127);
    load_sample(IDX_W'(GRID_SLOTS - 1), 32'h8000_0000);
    query_block(15, 15, 127);
    // out-of-range slots leave the grid alone
    load_sample(IDX_W'(GRID_SLOTS), 32'h0000_0100);
    load_sample(9'd511, 32'hFFFF_FFFF);
    query_block(15, 15, 127);
    // cell boundaries
    query_block(7, 8, 3);
    query_block(8, 7, 4);
    query_block(15, 0, 64);

    // random phases, each under its own solid code
    for (p = 0; p < PHASES; p++) begin
      write_solid_code(phase_code[p]);
      case (p)
        1:       begin gap_pct = 35; stall_pct = 35; end
        2:       begin gap_pct = 0;  stall_pct = 20; end
        3:       begin gap_pct = 20; stall_pct = 0;  end
        4:       begin gap_pct = 0;  stall_pct = 0;  end
        default: begin gap_pct = 10; stall_pct = 10; end
      endcase
      for (k = 0; k < PHASE_REQS; k++) begin
        random_request();
      end
    end

    wait_drained();
    repeat (16) @(posedge clk);
    if (mismatches == 0) begin
      $display("trilinear_voxel_upsample_threshold_top_tb OK");
    end else begin
      $display("trilinear_voxel_upsample_threshold_top_tb NOT OK");
    end
    $finish;
  end

endmodule
